/* design/ldir_pkg.sv */
// Shared constants, types and helpers for the LRU block cache directory.
// No dependencies; the interfaces and the directory import this package.
package ldir_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int BLOCK_BYTES = 4096;

    localparam int SW        = $clog2(NUM_SLOTS);
    localparam int UW        = $clog2(NUM_SLOTS + 1);
    localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int OP_W      = 2;
    localparam int FS_W      = 8;
    localparam int POS_W     = 32;
    localparam int BLK_W     = 20;
    localparam int SLOT_W    = 4;
    localparam int TAG_W     = FS_W + BLK_W;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_FL_FIND,
        S_FL_EMIT,
        S_FL_NONE
    } t_state;

    // Map a slot index onto the 4-bit result field.
    function automatic logic [SLOT_W-1:0] to_slot(input logic [SW-1:0] idx);
        logic [SW+SLOT_W-1:0] tmp;
        tmp = {{SLOT_W{1'b0}}, idx};
        return tmp[SLOT_W-1:0];
    endfunction

    // Block number: position divided by the block size, low bits kept.
    function automatic logic [BLK_W-1:0] block_of(input logic [POS_W-1:0] pos);
        logic [POS_W+BLK_W-1:0] sh;
        sh = {{BLK_W{1'b0}}, pos} >> BLK_SHIFT;
        return sh[BLK_W-1:0];
    endfunction

endpackage

/* design/ldir_if.sv */
// Request and response channel interfaces of the cache directory.
// Depends on ldir_pkg for field widths.
interface ldir_req_if;
    import ldir_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [FS_W-1:0]   fs_id;
    logic [POS_W-1:0]  pos;
    modport source (output valid, opcode, fs_id, pos, input ready);
    modport sink   (input valid, opcode, fs_id, pos, output ready);
endinterface

interface ldir_rsp_if;
    import ldir_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              fetch_needed;
    logic              writeback_valid;
    logic [FS_W-1:0]   wb_fs_id;
    logic [BLK_W-1:0]  wb_block;
    logic              last;
    modport source (output valid, slot, hit, fetch_needed, writeback_valid,
                    wb_fs_id, wb_block, last, input ready);
    modport sink   (input valid, slot, hit, fetch_needed, writeback_valid,
                    wb_fs_id, wb_block, last, output ready);
endinterface

/* design/ldir_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, then registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lru_writeback_block_cache_directory.sv */
// Access: an accept state, a scan that reads every tag RAM slot in turn, then a decide state
// that waits for the result register to be free; the registered tag RAM read port paces the scan.
// Flush: steps through the ranks from least recent and emits each dirty entry in rank order.
// One item at a time; the result register lets the next item be taken meanwhile.
// Synchronous active-low reset clears valid/dirty marks, fill count and control;
// the tag RAM holds no reset and its data is used only for valid slots.
module lru_writeback_block_cache_directory (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ldir_req_if.sink   i_req,
    ldir_rsp_if.source o_rsp
);
    import ldir_pkg::*;

    t_state r_state, n_state;

    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [NUM_SLOTS-1:0] r_dirty, n_dirty;
    logic [SW-1:0]        r_rank [NUM_SLOTS];
    logic [SW-1:0]        n_rank [NUM_SLOTS];
    logic [UW-1:0]        r_used, n_used;

    // Latched request
    logic [OP_W-1:0]  r_op;
    logic [FS_W-1:0]  r_fs;
    logic [BLK_W-1:0] r_blk;

    // Scan pipeline
    logic [UW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [SW-1:0]    r_pidx;
    logic             r_hit, n_hit;
    logic [SW-1:0]    r_hslot, n_hslot;
    logic [SW-1:0]    r_vslot, n_vslot;
    logic [TAG_W-1:0] r_vtag, n_vtag;

    // Flush walk
    logic [UW-1:0]    r_frank, n_frank;
    logic [SW-1:0]    r_fslot, n_fslot;
    logic             r_flast, n_flast;

    // Result register
    logic              r_ov, n_ov;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_ohit, n_ohit;
    logic              r_fetch, n_fetch;
    logic              r_wbv, n_wbv;
    logic [FS_W-1:0]   r_wfs, n_wfs;
    logic [BLK_W-1:0]  r_wblk, n_wblk;
    logic              r_last, n_last;

    // RAM ports
    logic             ram_we, ram_re;
    logic [SW-1:0]    ram_waddr, ram_raddr;
    logic [TAG_W-1:0] ram_wdata, ram_rdata;

    logic          out_free;
    logic          any_dirty;
    logic [SW-1:0] free_idx;

    ldir_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SLOTS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free        = !r_ov || o_rsp.ready;
    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.slot      = r_slot;
    assign o_rsp.hit       = r_ohit;
    assign o_rsp.fetch_needed    = r_fetch;
    assign o_rsp.writeback_valid = r_wbv;
    assign o_rsp.wb_fs_id  = r_wfs;
    assign o_rsp.wb_block  = r_wblk;
    assign o_rsp.last      = r_last;

    // Lowest free slot and any dirty entry
    always_comb begin
        free_idx  = '0;
        any_dirty = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SW'(i);
            end
            if (r_valid[i] && r_dirty[i]) begin
                any_dirty = 1'b1;
            end
        end
    end

    // State machine, directory update and result formation
    always_comb begin
        logic [SW-1:0]  s;
        logic [SW-1:0]  sr;
        logic           wbv;
        logic           fnd;
        logic           later;
        logic [SW-1:0]  fsel;

        n_state = r_state;
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_rank  = r_rank;
        n_used  = r_used;
        n_idx   = r_idx;
        n_pend  = 1'b0;
        n_hit   = r_hit;
        n_hslot = r_hslot;
        n_vslot = r_vslot;
        n_vtag  = r_vtag;
        n_frank = r_frank;
        n_fslot = r_fslot;
        n_flast = r_flast;
        n_ov    = r_ov && !o_rsp.ready;
        n_slot  = r_slot;
        n_ohit  = r_ohit;
        n_fetch = r_fetch;
        n_wbv   = r_wbv;
        n_wfs   = r_wfs;
        n_wblk  = r_wblk;
        n_last  = r_last;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {r_fs, r_blk};
        ram_re    = 1'b0;
        ram_raddr = '0;
        s     = '0;
        sr    = '0;
        wbv   = 1'b0;
        fnd   = 1'b0;
        later = 1'b0;
        fsel  = '0;

        // Compare returned tags, remember the hit and the LRU victim
        if (r_pend) begin
            if (r_valid[r_pidx] && ram_rdata == {r_fs, r_blk}) begin
                n_hit   = 1'b1;
                n_hslot = r_pidx;
            end
            if (r_valid[r_pidx] && r_rank[r_pidx] == '0) begin
                n_vslot = r_pidx;
                n_vtag  = ram_rdata;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                n_idx   = '0;
                n_hit   = 1'b0;
                n_frank = '0;
                if (i_req.valid) begin
                    if (i_req.opcode == OP_FLUSH) begin
                        n_state = any_dirty ? S_FL_FIND : S_FL_NONE;
                    end else if (i_req.opcode == OP_READ || i_req.opcode == OP_WRITE) begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_idx < UW'(NUM_SLOTS)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[SW-1:0];
                    n_pend    = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                if (out_free) begin
                    if (r_hit) begin
                        s = r_hslot;
                    end else if (r_used < UW'(NUM_SLOTS)) begin
                        s = free_idx;
                    end else begin
                        s   = r_vslot;
                        wbv = r_dirty[r_vslot];
                    end
                    sr = r_rank[s];
                    if (r_hit || r_used == UW'(NUM_SLOTS)) begin
                        // Move s to most recent
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (SW'(i) != s && r_valid[i] && r_rank[i] > sr) begin
                                n_rank[i] = r_rank[i] - 1'b1;
                            end
                        end
                        n_rank[s] = SW'(r_used - 1'b1);
                    end else begin
                        n_valid[s] = 1'b1;
                        n_rank[s]  = SW'(r_used);
                        n_used     = r_used + 1'b1;
                    end
                    if (r_hit) begin
                        n_dirty[s] = r_dirty[s] || (r_op == OP_WRITE);
                    end else begin
                        n_dirty[s] = (r_op == OP_WRITE);
                        ram_we     = 1'b1;
                        ram_waddr  = s;
                    end
                    n_ov    = 1'b1;
                    n_slot  = to_slot(s);
                    n_ohit  = r_hit;
                    n_fetch = !r_hit && (r_op == OP_READ);
                    n_wbv   = wbv;
                    n_wfs   = wbv ? r_vtag[TAG_W-1:BLK_W] : '0;
                    n_wblk  = wbv ? r_vtag[BLK_W-1:0] : '0;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_FL_FIND: begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (r_valid[i] && r_dirty[i] && UW'(r_rank[i]) == r_frank) begin
                        fnd  = 1'b1;
                        fsel = SW'(i);
                    end
                    if (r_valid[i] && r_dirty[i] && UW'(r_rank[i]) > r_frank) begin
                        later = 1'b1;
                    end
                end
                n_frank = r_frank + 1'b1;
                if (fnd) begin
                    ram_re    = 1'b1;
                    ram_raddr = fsel;
                    n_fslot   = fsel;
                    n_flast   = !later;
                    n_state   = S_FL_EMIT;
                end
            end

            S_FL_EMIT: begin
                if (out_free) begin
                    n_dirty[r_fslot] = 1'b0;
                    n_ov    = 1'b1;
                    n_slot  = to_slot(r_fslot);
                    n_ohit  = 1'b0;
                    n_fetch = 1'b0;
                    n_wbv   = 1'b1;
                    n_wfs   = ram_rdata[TAG_W-1:BLK_W];
                    n_wblk  = ram_rdata[BLK_W-1:0];
                    n_last  = r_flast;
                    n_state = r_flast ? S_IDLE : S_FL_FIND;
                end
            end

            S_FL_NONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_slot  = '0;
                    n_ohit  = 1'b0;
                    n_fetch = 1'b0;
                    n_wbv   = 1'b0;
                    n_wfs   = '0;
                    n_wblk  = '0;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_used  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_used  <= n_used;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op  <= i_req.opcode;
            r_fs  <= i_req.fs_id;
            r_blk <= block_of(i_req.pos);
        end
        r_rank  <= n_rank;
        r_idx   <= n_idx;
        r_pidx  <= r_idx[SW-1:0];
        r_hit   <= n_hit;
        r_hslot <= n_hslot;
        r_vslot <= n_vslot;
        r_vtag  <= n_vtag;
        r_frank <= n_frank;
        r_fslot <= n_fslot;
        r_flast <= n_flast;
        r_slot  <= n_slot;
        r_ohit  <= n_ohit;
        r_fetch <= n_fetch;
        r_wbv   <= n_wbv;
        r_wfs   <= n_wfs;
        r_wblk  <= n_wblk;
        r_last  <= n_last;
    end

    // Fill count never exceeds the slot count
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(NUM_SLOTS))
        else $error("fill count above slot count");

    // Fill count tracks the valid marks
    a_used_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UW'($countones(r_valid)) == r_used)
        else $error("fill count disagrees with valid marks");

    // Flushed entry is still valid and dirty while its result waits
    a_flush_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FL_EMIT |-> r_dirty[r_fslot] && r_valid[r_fslot])
        else $error("flush picked a clean entry");

    // Decision only after the scan pipeline has drained
    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEC |-> !r_pend && r_idx == UW'(NUM_SLOTS))
        else $error("decision taken before scan finished");

endmodule
